// ----- hdl/lgf_pkg.sv -----
// ----------------------------------------------------------------------------
// lgf_pkg
// Shared widths, constants and the sequencer state type of the launch grid
// factorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lgf_pkg;

    localparam int unsigned WIDE_W   = 64;
    localparam int unsigned GRID_W   = 32;
    localparam int unsigned EXT_W    = 31;
    localparam int unsigned PROD_W   = WIDE_W + EXT_W;
    localparam int unsigned DCNT_W   = 7;
    localparam int unsigned MCNT_W   = 5;

    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(WIDE_W);
    localparam logic [MCNT_W-1:0] MUL_STEPS = MCNT_W'(EXT_W);

    localparam logic [GRID_W-1:0] GRID_MAX = {GRID_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ABS_X,
        ST_ABS_Y,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/lgf_div.sv -----
// ----------------------------------------------------------------------------
// lgf_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lgf_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lgf_pkg::WIDE_W-1:0] dividend,
    input  wire logic [lgf_pkg::WIDE_W-1:0] divisor,
    output logic                            done,
    output logic [lgf_pkg::WIDE_W-1:0]      quotient,
    output logic [lgf_pkg::WIDE_W-1:0]      remainder
);

    logic [lgf_pkg::WIDE_W-1:0] n_reg, n_next;
    logic [lgf_pkg::WIDE_W-1:0] d_reg, d_next;
    logic [lgf_pkg::WIDE_W-1:0] r_reg, r_next;
    logic [lgf_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [lgf_pkg::WIDE_W:0]   shifted;
    logic [lgf_pkg::WIDE_W+1:0] diff;

    always_comb
    begin
        shifted   = {r_reg, n_reg[lgf_pkg::WIDE_W-1]};
        diff      = {1'b0, shifted} - {2'b00, d_reg};
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = dividend;
            d_next    = divisor;
            r_next    = '0;
            cnt_next  = lgf_pkg::DIV_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A negative trial difference means the bit is zero; keep the shift.
            n_next = {n_reg[lgf_pkg::WIDE_W-2:0], ~diff[lgf_pkg::WIDE_W+1]};
            r_next = diff[lgf_pkg::WIDE_W+1] ? shifted[lgf_pkg::WIDE_W-1:0]
                                               : diff[lgf_pkg::WIDE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lgf_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = n_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

// ----- hdl/lgf_mul.sv -----
// ----------------------------------------------------------------------------
// lgf_mul
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lgf_mul (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lgf_pkg::WIDE_W-1:0] multiplicand,
    input  wire logic [lgf_pkg::EXT_W-1:0]  multiplier,
    output logic                            done,
    output logic [lgf_pkg::PROD_W-1:0]      product
);

    logic [lgf_pkg::WIDE_W-1:0] a_reg, a_next;
    logic [lgf_pkg::EXT_W-1:0]  b_reg, b_next;
    logic [lgf_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [lgf_pkg::MCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = multiplicand;
            b_next    = multiplier;
            acc_next  = '0;
            cnt_next  = lgf_pkg::MUL_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Multiplier bits are taken most significant first.
            acc_next = {acc_reg[lgf_pkg::PROD_W-2:0], 1'b0}
                     + (b_reg[lgf_pkg::EXT_W-1]
                        ? {{lgf_pkg::EXT_W{1'b0}}, a_reg} : '0);
            b_next   = {b_reg[lgf_pkg::EXT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lgf_pkg::MCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ----- hdl/launch_grid_factorizer.sv -----
// ----------------------------------------------------------------------------
// launch_grid_factorizer
// Builds a two-dimensional launch grid from a stream of array dimensions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | first, thread_count, extent,
//          |           |                    | stride_is_zero, last
//  out     | output    | out_valid/out_stall| grid_major, grid_minor,
//          |           |                    | factor_error
//
// A skipped dimension is handled in ST_IDLE alone; any other item makes up
// to three passes of the serial divider and up to two passes of the serial
// multiplier. A last item then goes through ST_OUT to load the result
// register.
// One item is worked on at a time; in_stall is high while an item is busy.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only if its own result finds the register still full.
// Reset gives x = 1, y = 1, no threads left and no overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module launch_grid_factorizer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        first,
    input  wire logic [lgf_pkg::WIDE_W-1:0]  thread_count,
    input  wire logic [lgf_pkg::EXT_W-1:0]   extent,
    input  wire logic                        stride_is_zero,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lgf_pkg::GRID_W-1:0]       grid_major,
    output logic [lgf_pkg::GRID_W-1:0]       grid_minor,
    output logic                             factor_error
);

    lgf_pkg::state_t state_reg, state_next;

    logic [lgf_pkg::GRID_W-1:0] x_reg, x_next;
    logic [lgf_pkg::WIDE_W-1:0] y_reg, y_next;
    logic [lgf_pkg::WIDE_W-1:0] t_reg, t_next;
    logic                       ovf_reg, ovf_next;
    logic [lgf_pkg::EXT_W-1:0]  ext_reg, ext_next;
    logic                       last_reg, last_next;
    logic                       launched_reg, launched_next;

    logic                       ov_reg, ov_next;
    logic [lgf_pkg::GRID_W-1:0] maj_reg, maj_next;
    logic [lgf_pkg::GRID_W-1:0] min_reg, min_next;
    logic                       err_reg, err_next;

    logic                       div_start, div_done;
    logic [lgf_pkg::WIDE_W-1:0] div_num, div_den, div_quot, div_rem;
    logic                       mul_start, mul_done;
    logic [lgf_pkg::WIDE_W-1:0] mul_a;
    logic [lgf_pkg::PROD_W-1:0] mul_prod;

    logic                       accept;
    logic                       slot_free;
    logic                       err_now;
    logic                       y_small;
    logic                       t_big;

    lgf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    lgf_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_a),
        .multiplier   (ext_reg),
        .done         (mul_done),
        .product      (mul_prod)
    );

    assign accept    = in_valid && !in_stall;
    assign slot_free = !ov_reg || !out_stall;
    assign t_big     = t_reg > lgf_pkg::WIDE_W'(1);
    assign y_small   = y_reg[lgf_pkg::WIDE_W-1:lgf_pkg::GRID_W] == '0;
    assign err_now   = ovf_reg || !y_small || t_big;

    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        t_next        = t_reg;
        ovf_next      = ovf_reg;
        ext_next      = ext_reg;
        last_next     = last_reg;
        launched_next = launched_reg;
        ov_next       = ov_reg;
        maj_next      = maj_reg;
        min_next      = min_reg;
        err_next      = err_reg;
        in_stall      = 1'b1;
        div_start     = 1'b0;
        mul_start     = 1'b0;
        div_num       = t_reg;
        div_den       = {{(lgf_pkg::WIDE_W-lgf_pkg::EXT_W){1'b0}}, ext_reg};
        mul_a         = {{(lgf_pkg::WIDE_W-lgf_pkg::GRID_W){1'b0}}, x_reg};

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            lgf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ext_next  = extent;
                    last_next = last;
                    if (first)
                    begin
                        x_next   = lgf_pkg::GRID_W'(1);
                        y_next   = lgf_pkg::WIDE_W'(1);
                        ovf_next = 1'b0;
                        t_next   = thread_count;
                    end
                    priority if (stride_is_zero)
                    begin
                        state_next = last ? lgf_pkg::ST_OUT : lgf_pkg::ST_IDLE;
                    end
                    else if (extent != '0)
                    begin
                        state_next = lgf_pkg::ST_DIV_T;
                    end
                    else
                    begin
                        state_next = lgf_pkg::ST_MUL_X;
                    end
                end
            end

            lgf_pkg::ST_DIV_T:
            begin
                div_start = !launched_reg;
                if (div_start)
                begin
                    launched_next = 1'b1;
                end
                if (div_done)
                begin
                    launched_next = 1'b0;
                    if (div_rem == '0)
                    begin
                        t_next     = div_quot;
                        state_next = last_reg ? lgf_pkg::ST_OUT : lgf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lgf_pkg::ST_MUL_X;
                    end
                end
            end

            lgf_pkg::ST_MUL_X:
            begin
                mul_start = !launched_reg;
                if (mul_start)
                begin
                    launched_next = 1'b1;
                end
                if (mul_done)
                begin
                    launched_next = 1'b0;
                    if (mul_prod[lgf_pkg::PROD_W-1:lgf_pkg::GRID_W] == '0 &&
                        mul_prod[lgf_pkg::GRID_W-1:0] != lgf_pkg::GRID_MAX)
                    begin
                        x_next     = mul_prod[lgf_pkg::GRID_W-1:0];
                        state_next = t_big ? lgf_pkg::ST_ABS_X
                                   : (last_reg ? lgf_pkg::ST_OUT : lgf_pkg::ST_IDLE);
                    end
                    else
                    begin
                        state_next = lgf_pkg::ST_MUL_Y;
                    end
                end
            end

            lgf_pkg::ST_MUL_Y:
            begin
                mul_a     = y_reg;
                mul_start = !launched_reg;
                if (mul_start)
                begin
                    launched_next = 1'b1;
                end
                if (mul_done)
                begin
                    launched_next = 1'b0;
                    // Any bit at 64 or above means the product would wrap, so y saturates.
                    if (mul_prod[lgf_pkg::PROD_W-1:lgf_pkg::WIDE_W] != '0)
                    begin
                        y_next   = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        y_next = mul_prod[lgf_pkg::WIDE_W-1:0];
                    end
                    state_next = t_big ? lgf_pkg::ST_ABS_X
                               : (last_reg ? lgf_pkg::ST_OUT : lgf_pkg::ST_IDLE);
                end
            end

            lgf_pkg::ST_ABS_X:
            begin
                div_num   = {{(lgf_pkg::WIDE_W-lgf_pkg::GRID_W){1'b0}}, x_reg};
                div_den   = t_reg;
                div_start = !launched_reg;
                if (div_start)
                begin
                    launched_next = 1'b1;
                end
                if (div_done)
                begin
                    launched_next = 1'b0;
                    if (div_rem == '0)
                    begin
                        x_next     = div_quot[lgf_pkg::GRID_W-1:0];
                        t_next     = lgf_pkg::WIDE_W'(1);
                        state_next = last_reg ? lgf_pkg::ST_OUT : lgf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lgf_pkg::ST_ABS_Y;
                    end
                end
            end

            lgf_pkg::ST_ABS_Y:
            begin
                div_num   = y_reg;
                div_den   = t_reg;
                div_start = !launched_reg;
                if (div_start)
                begin
                    launched_next = 1'b1;
                end
                if (div_done)
                begin
                    launched_next = 1'b0;
                    if (div_rem == '0)
                    begin
                        y_next = div_quot;
                        t_next = lgf_pkg::WIDE_W'(1);
                    end
                    state_next = last_reg ? lgf_pkg::ST_OUT : lgf_pkg::ST_IDLE;
                end
            end

            lgf_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    err_next = err_now;
                    if (err_now)
                    begin
                        maj_next = '0;
                        min_next = '0;
                    end
                    else if (y_reg[lgf_pkg::GRID_W-1:0] > x_reg)
                    begin
                        maj_next = y_reg[lgf_pkg::GRID_W-1:0];
                        min_next = x_reg;
                    end
                    else
                    begin
                        maj_next = x_reg;
                        min_next = y_reg[lgf_pkg::GRID_W-1:0];
                    end
                    state_next = lgf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lgf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lgf_pkg::ST_IDLE;
            x_reg        <= lgf_pkg::GRID_W'(1);
            y_reg        <= lgf_pkg::WIDE_W'(1);
            t_reg        <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
            launched_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            t_reg        <= t_next;
            ovf_reg      <= ovf_next;
            last_reg     <= last_next;
            launched_reg <= launched_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ext_reg <= ext_next;
        maj_reg <= maj_next;
        min_reg <= min_next;
        err_reg <= err_next;
    end

    assign out_valid    = ov_reg;
    assign grid_major   = maj_reg;
    assign grid_minor   = min_reg;
    assign factor_error = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && factor_error |-> grid_major == '0 && grid_minor == '0)
        else $error("error result carries nonzero grid sizes");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !factor_error |-> grid_major >= grid_minor)
        else $error("grid sizes out of order");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_start && mul_start))
        else $error("divider and multiplier started together");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != lgf_pkg::ST_IDLE || !last_reg || $past(stride_is_zero))
        else $error("item with work returned to idle at once");

endmodule

`default_nettype wire
